@@ rtl/ots_pkg.sv @@
// Package for the operator token scanner: token kinds, scan modes, result
// record types and byte classification helpers.
// No dependencies.
package ots_pkg;

  // Width of the byte position counter
  localparam int unsigned PosBits   = 16;
  // Result queue depth; room for the two results of one byte is required
  localparam int unsigned FifoDepth = 4;

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  // Characters with special meaning
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;

  // Token kinds
  localparam logic [4:0] KIND_END          = 5'd0;
  localparam logic [4:0] KIND_IDENT        = 5'd1;
  localparam logic [4:0] KIND_NUMBER       = 5'd2;
  localparam logic [4:0] KIND_PLUS         = 5'd3;
  localparam logic [4:0] KIND_INCR         = 5'd4;
  localparam logic [4:0] KIND_PLUS_ASSIGN  = 5'd5;
  localparam logic [4:0] KIND_MINUS        = 5'd6;
  localparam logic [4:0] KIND_DECR         = 5'd7;
  localparam logic [4:0] KIND_MINUS_ASSIGN = 5'd8;
  localparam logic [4:0] KIND_ARROW        = 5'd9;
  localparam logic [4:0] KIND_MUL          = 5'd10;
  localparam logic [4:0] KIND_MUL_ASSIGN   = 5'd11;
  localparam logic [4:0] KIND_DIV          = 5'd12;
  localparam logic [4:0] KIND_DIV_ASSIGN   = 5'd13;
  localparam logic [4:0] KIND_MOD          = 5'd14;
  localparam logic [4:0] KIND_MOD_ASSIGN   = 5'd15;
  localparam logic [4:0] KIND_ASSIGN       = 5'd16;
  localparam logic [4:0] KIND_QUESTION     = 5'd17;
  localparam logic [4:0] KIND_LPAREN       = 5'd18;
  localparam logic [4:0] KIND_RPAREN       = 5'd19;
  localparam logic [4:0] KIND_LBRACE       = 5'd20;
  localparam logic [4:0] KIND_RBRACE       = 5'd21;
  localparam logic [4:0] KIND_LBRACKET     = 5'd22;
  localparam logic [4:0] KIND_RBRACKET     = 5'd23;
  localparam logic [4:0] KIND_DQUOTE       = 5'd24;
  localparam logic [4:0] KIND_SQUOTE       = 5'd25;
  localparam logic [4:0] KIND_SEMI         = 5'd26;
  localparam logic [4:0] KIND_COLON        = 5'd27;
  localparam logic [4:0] KIND_DOT          = 5'd28;
  localparam logic [4:0] KIND_COMMA        = 5'd29;
  localparam logic [4:0] KIND_BANG         = 5'd30;
  localparam logic [4:0] KIND_ERROR        = 5'd31;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_PLUS,
    MODE_MINUS,
    MODE_STAR,
    MODE_SLASH,
    MODE_PERCENT,
    MODE_HALT
  } mode_e;

  // One result record
  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } tok_t;

  // Decision for one byte: up to two results plus the next scanner state
  typedef struct packed {
    tok_t               res0;
    tok_t               res1;
    logic [1:0]         count;
    mode_e              mode;
    logic [PosBits-1:0] pos;
    logic [PosBits-1:0] pstart;
  } scan_out_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Single punctuation kind, KIND_END when the byte is not punctuation
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_END;
    case (c)
      8'h3D:   k = KIND_ASSIGN;
      8'h3F:   k = KIND_QUESTION;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h22:   k = KIND_DQUOTE;
      8'h27:   k = KIND_SQUOTE;
      8'h3B:   k = KIND_SEMI;
      8'h3A:   k = KIND_COLON;
      8'h2E:   k = KIND_DOT;
      8'h2C:   k = KIND_COMMA;
      8'h21:   k = KIND_BANG;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  // Saturate a position-sized value to the 16-bit result field
  function automatic logic [15:0] sat16(input logic [PosBits-1:0] v);
    logic [PosBits+15:0] w;
    w = {16'b0, v};
    if (w > (PosBits+16)'(17'h0FFFF)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

@@ rtl/ots_lexer.sv @@
// Per-byte scan decision: flushes the pending token, classifies the current
// byte and computes the next scanner state. Purely combinational.
// Depends on ots_pkg.
module ots_lexer import ots_pkg::*; (
  input  mode_e              mode_i,
  input  logic [PosBits-1:0] pos_i,
  input  logic [PosBits-1:0] pstart_i,
  input  logic [7:0]         byte_i,
  output scan_out_t          scan_o
);

  logic               consumed;
  logic               pend_v;
  tok_t               pend;
  logic               cur_v;
  tok_t               cur;
  logic [PosBits-1:0] run_diff;
  logic [PosBits-1:0] run_len;
  logic [4:0]         pkind;

  // Length of the pending run, never below one once the position saturates
  assign run_diff = pos_i - pstart_i;
  assign run_len  = (run_diff == '0) ? PosBits'(1) : run_diff;
  assign pkind    = punct_kind(byte_i);

  // Resolve the pending token against the lookahead byte
  always_comb begin
    consumed = 1'b0;
    pend_v   = 1'b0;
    pend     = '{kind: KIND_END, start: sat16(pstart_i), length: 16'd1, last: 1'b0};
    unique case (mode_i)
      MODE_IDENT: begin
        if (is_alpha(byte_i)) begin
          consumed = 1'b1;
        end else begin
          pend_v      = 1'b1;
          pend.kind   = KIND_IDENT;
          pend.length = sat16(run_len);
        end
      end
      MODE_NUMBER: begin
        if (is_digit(byte_i)) begin
          consumed = 1'b1;
        end else begin
          pend_v      = 1'b1;
          pend.kind   = KIND_NUMBER;
          pend.length = sat16(run_len);
        end
      end
      MODE_PLUS: begin
        pend_v = 1'b1;
        if (byte_i == CH_PLUS) begin
          consumed = 1'b1; pend.kind = KIND_INCR; pend.length = 16'd2;
        end else if (byte_i == CH_EQ) begin
          consumed = 1'b1; pend.kind = KIND_PLUS_ASSIGN; pend.length = 16'd2;
        end else begin
          pend.kind = KIND_PLUS;
        end
      end
      MODE_MINUS: begin
        pend_v = 1'b1;
        if (byte_i == CH_MINUS) begin
          consumed = 1'b1; pend.kind = KIND_DECR; pend.length = 16'd2;
        end else if (byte_i == CH_EQ) begin
          consumed = 1'b1; pend.kind = KIND_MINUS_ASSIGN; pend.length = 16'd2;
        end else if (byte_i == CH_GT) begin
          consumed = 1'b1; pend.kind = KIND_ARROW; pend.length = 16'd2;
        end else begin
          pend.kind = KIND_MINUS;
        end
      end
      MODE_STAR: begin
        pend_v = 1'b1;
        if (byte_i == CH_EQ) begin
          consumed = 1'b1; pend.kind = KIND_MUL_ASSIGN; pend.length = 16'd2;
        end else begin
          pend.kind = KIND_MUL;
        end
      end
      MODE_SLASH: begin
        pend_v = 1'b1;
        if (byte_i == CH_EQ) begin
          consumed = 1'b1; pend.kind = KIND_DIV_ASSIGN; pend.length = 16'd2;
        end else begin
          pend.kind = KIND_DIV;
        end
      end
      MODE_PERCENT: begin
        pend_v = 1'b1;
        if (byte_i == CH_EQ) begin
          consumed = 1'b1; pend.kind = KIND_MOD_ASSIGN; pend.length = 16'd2;
        end else begin
          pend.kind = KIND_MOD;
        end
      end
      MODE_IDLE, MODE_HALT: begin
        pend_v = 1'b0;
      end
      default: begin
        pend_v = 1'b0;
      end
    endcase
  end

  // Token caused by the current byte itself when it was not consumed
  always_comb begin
    cur_v = 1'b0;
    cur   = '{kind: KIND_END, start: sat16(pos_i), length: 16'd1, last: 1'b1};
    if (mode_i != MODE_HALT && !consumed) begin
      if (byte_i == CH_NUL) begin
        cur_v      = 1'b1;
        cur.length = 16'd0;
      end else if (is_space(byte_i) || is_alpha(byte_i) || is_digit(byte_i) ||
                   byte_i == CH_PLUS || byte_i == CH_MINUS || byte_i == CH_STAR ||
                   byte_i == CH_SLASH || byte_i == CH_PERCENT) begin
        cur_v = 1'b0;
      end else if (pkind != KIND_END) begin
        cur_v    = 1'b1;
        cur.kind = pkind;
      end else begin
        cur_v    = 1'b1;
        cur.kind = KIND_ERROR;
      end
    end
  end

  // Next scanner state; order the results, pending token first, the last one flagged
  always_comb begin
    scan_o.mode   = mode_i;
    scan_o.pstart = pstart_i;
    scan_o.pos    = (pos_i != PosMax) ? pos_i + PosBits'(1) : pos_i;
    if (mode_i == MODE_HALT) begin
      scan_o.pos = pos_i;
    end else if (consumed) begin
      if (mode_i != MODE_IDENT && mode_i != MODE_NUMBER) begin
        scan_o.mode = MODE_IDLE;
      end
    end else begin
      scan_o.mode   = MODE_IDLE;
      scan_o.pstart = pos_i;
      if (byte_i == CH_NUL) begin
        scan_o.pos    = '0;
        scan_o.pstart = pstart_i;
      end else if (is_alpha(byte_i)) begin
        scan_o.mode = MODE_IDENT;
      end else if (is_digit(byte_i)) begin
        scan_o.mode = MODE_NUMBER;
      end else if (byte_i == CH_PLUS) begin
        scan_o.mode = MODE_PLUS;
      end else if (byte_i == CH_MINUS) begin
        scan_o.mode = MODE_MINUS;
      end else if (byte_i == CH_STAR) begin
        scan_o.mode = MODE_STAR;
      end else if (byte_i == CH_SLASH) begin
        scan_o.mode = MODE_SLASH;
      end else if (byte_i == CH_PERCENT) begin
        scan_o.mode = MODE_PERCENT;
      end else begin
        // hold start for skipped or single-character bytes
        scan_o.pstart = pstart_i;
        if (!is_space(byte_i) && pkind == KIND_END) begin
          scan_o.mode = MODE_HALT;
        end
      end
    end

    scan_o.res0  = cur;
    scan_o.res1  = cur;
    scan_o.count = {1'b0, cur_v};
    if (pend_v) begin
      scan_o.res0      = pend;
      scan_o.res0.last = !cur_v;
      scan_o.count     = cur_v ? 2'd2 : 2'd1;
    end
  end

endmodule

@@ rtl/ots_tok_fifo.sv @@
// Result queue: takes zero, one or two token records per cycle and hands
// out one per transaction. Register based, depth from ots_pkg.
// Depends on ots_pkg.
module ots_tok_fifo import ots_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  tok_t       push0_i,
  input  tok_t       push1_i,
  output logic       room_o,
  input  logic       pop_i,
  output logic       valid_o,
  output tok_t       head_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  tok_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;
  logic [PtrW-1:0] wr_next;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign room_o  = (cnt_q <= CntW'(FifoDepth - 2));
  assign do_pop  = pop_i && valid_o;
  assign wr_next = wr_ptr_q + PtrW'(1);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_cnt_i) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store records; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_next] <= push1_i;
    end
  end

endmodule

@@ rtl/operator_token_scanner.sv @@
// Top level of the operator token scanner: scan state registers, per-byte
// decision logic and the result queue.
// Depends on ots_pkg, ots_lexer and ots_tok_fifo.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | in_valid_i / in_ready_o   | text_byte_i
//  output   | out_valid_o / out_ready_i | token_kind_o, token_start_o,
//           |                           | token_length_o, last_of_run_o
//
// One byte is accepted per cycle while in_ready_o is high; its results
// enter the result queue at the same edge and the first can be taken in
// the next cycle. A byte can cause two results while the output moves at
// most one per cycle, so the four-entry queue sets the input rate: input
// stalls while fewer than two entries are free.
// Reset clears the scan mode, position and queue; no clearing pass is needed.
// After an error token every byte is accepted and dropped until reset.
module operator_token_scanner import ots_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic        last_of_run_o
);

  mode_e              mode_q, mode_d;
  logic [PosBits-1:0] pos_q, pos_d;
  logic [PosBits-1:0] pstart_q, pstart_d;
  scan_out_t          scan;
  logic               in_fire;
  logic [1:0]         push_cnt;
  tok_t               head;

  assign in_fire  = in_valid_i && in_ready_o;
  assign push_cnt = in_fire ? scan.count : 2'd0;

  ots_lexer u_lexer (
    .mode_i   (mode_q),
    .pos_i    (pos_q),
    .pstart_i (pstart_q),
    .byte_i   (text_byte_i),
    .scan_o   (scan)
  );

  ots_tok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (scan.res0),
    .push1_i    (scan.res1),
    .room_o     (in_ready_o),
    .pop_i      (out_ready_i),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  // Advance scan state on each accepted byte
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    pstart_d = pstart_q;
    if (in_fire) begin
      mode_d   = scan.mode;
      pos_d    = scan.pos;
      pstart_d = scan.pstart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
    end
  end

  assign token_kind_o   = head.kind;
  assign token_start_o  = head.start;
  assign token_length_o = head.length;
  assign last_of_run_o  = head.last;

  // Halted scanner produces nothing and keeps its position
  a_halt_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q == MODE_HALT) |-> (push_cnt == 2'd0 && pos_d == pos_q))
    else $error("halted scanner produced a result or moved");

  // End of text restarts the position at zero
  a_end_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_q != MODE_HALT && text_byte_i == CH_NUL) |=> (pos_q == '0))
    else $error("position not restarted after end of text");

  // A single result pushed for a byte always carries the last flag
  a_last_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt == 2'd1) |-> scan.res0.last)
    else $error("single result without last flag");

  // Two results: first never flagged, second always flagged
  a_pair_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_cnt == 2'd2) |-> (!scan.res0.last && scan.res1.last))
    else $error("result pair flagged wrongly");

endmodule

@@ verif/tb_top.sv @@
// Testbench for operator_token_scanner: directed and random source text, with a
// behavioral scanner predicting every token. Depends on ots_pkg and the scanner RTL.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ots_pkg::*;

  // Stimulus row: one source byte, optionally with its single token typed in
  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    tok_t       want;
  } text_row_t;

  localparam tok_t  NoTok      = '0;
  localparam string PunctChars = "=?(){}[]\"';:.,!";
  localparam string OpPairs    = "+++=---=->*=/=%=";
  localparam string OpSingles  = "+-*/%";
  localparam int    RandItems  = 1000;
  localparam int    TailItems  = 200;

  // Short directed text: every two-character operator, lone operators,
  // letter and digit extremes, and a byte that flushes a token and emits one
  localparam text_row_t DirRows [27] = '{
    '{CH_NUL, 1'b1, '{KIND_END, 16'd0, 16'd0, 1'b1}},
    '{"(",    1'b1, '{KIND_LPAREN, 16'd0, 16'd1, 1'b1}},
    '{"A", 1'b0, NoTok}, '{"z", 1'b0, NoTok}, '{"0", 1'b0, NoTok}, '{"9", 1'b0, NoTok},
    '{"+", 1'b0, NoTok}, '{"+", 1'b0, NoTok}, '{"+", 1'b0, NoTok}, '{"=", 1'b0, NoTok},
    '{"-", 1'b0, NoTok}, '{"-", 1'b0, NoTok}, '{"-", 1'b0, NoTok}, '{">", 1'b0, NoTok},
    '{"-", 1'b0, NoTok}, '{"=", 1'b0, NoTok}, '{"*", 1'b0, NoTok}, '{"=", 1'b0, NoTok},
    '{"/", 1'b0, NoTok}, '{"=", 1'b0, NoTok}, '{"%", 1'b0, NoTok}, '{"=", 1'b0, NoTok},
    '{"-", 1'b0, NoTok}, '{"+", 1'b0, NoTok}, '{")", 1'b0, NoTok},
    '{8'h09, 1'b0, NoTok},
    '{CH_NUL, 1'b0, NoTok}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  text_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  token_kind_o;
  logic [15:0] token_start_o;
  logic [15:0] token_length_o;
  logic        last_of_run_o;

  // Scanner state as predicted
  mode_e              scan_mode;
  logic [PosBits-1:0] scan_pos;
  logic [PosBits-1:0] scan_pstart;

  tok_t       tokens_due [$];
  logic [7:0] text_buf [$];
  int         err_count;
  int         tokens_seen;
  logic       src_idle_on;
  logic       sink_idle_on;

  operator_token_scanner i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_start_o (token_start_o),
    .token_length_o(token_length_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Byte classes
  function automatic logic is_letter(input logic [7:0] c);
    logic [7:0] u;
    u = c & 8'hDF;
    return u >= 8'h41 && u <= 8'h5A;
  endfunction

  function automatic logic is_digit_ch(input logic [7:0] c);
    return c[7:4] == 4'h3 && c[3:0] <= 4'd9;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Punctuation kinds follow the order of PunctChars
  function automatic logic [4:0] punct_of(input logic [7:0] c);
    for (int i = 0; i < PunctChars.len(); i++) begin
      if (PunctChars[i] == c) return 5'(KIND_ASSIGN + i);
    end
    return KIND_END;
  endfunction

  function automatic logic [15:0] clip16(input logic [PosBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic tok_t make_tok(input logic [4:0] kind, input logic [PosBits-1:0] start,
                                    input logic [PosBits-1:0] len);
    tok_t t;
    t.kind   = kind;
    t.start  = clip16(start);
    t.length = clip16(len);
    t.last   = 1'b0;
    return t;
  endfunction

  // Length of the pending run; never below one once the position has saturated
  function automatic logic [PosBits-1:0] run_len(input logic [PosBits-1:0] p);
    logic [PosBits-1:0] len;
    len = p - scan_pstart;
    return (len == '0) ? PosBits'(1) : len;
  endfunction

  // Advance the predicted scanner by one byte and return the tokens it causes
  task automatic lex_byte(input logic [7:0] c, output int n, output tok_t res [2]);
    logic               taken;
    logic [PosBits-1:0] p;
    logic [4:0]         k;
    n      = 0;
    taken  = 1'b0;
    p      = scan_pos;
    res[0] = NoTok;
    res[1] = NoTok;
    if (scan_mode == MODE_HALT) return;

    // Extend or close the pending token
    case (scan_mode)
      MODE_IDENT: begin
        if (is_letter(c)) taken = 1'b1;
        else begin
          res[n] = make_tok(KIND_IDENT, scan_pstart, run_len(p));
          n++;
        end
      end
      MODE_NUMBER: begin
        if (is_digit_ch(c)) taken = 1'b1;
        else begin
          res[n] = make_tok(KIND_NUMBER, scan_pstart, run_len(p));
          n++;
        end
      end
      MODE_PLUS: begin
        taken = 1'b1;
        if (c == CH_PLUS) res[n] = make_tok(KIND_INCR, scan_pstart, PosBits'(2));
        else if (c == CH_EQ) res[n] = make_tok(KIND_PLUS_ASSIGN, scan_pstart, PosBits'(2));
        else begin
          res[n] = make_tok(KIND_PLUS, scan_pstart, PosBits'(1));
          taken  = 1'b0;
        end
        n++;
      end
      MODE_MINUS: begin
        taken = 1'b1;
        if (c == CH_MINUS) res[n] = make_tok(KIND_DECR, scan_pstart, PosBits'(2));
        else if (c == CH_EQ) res[n] = make_tok(KIND_MINUS_ASSIGN, scan_pstart, PosBits'(2));
        else if (c == CH_GT) res[n] = make_tok(KIND_ARROW, scan_pstart, PosBits'(2));
        else begin
          res[n] = make_tok(KIND_MINUS, scan_pstart, PosBits'(1));
          taken  = 1'b0;
        end
        n++;
      end
      MODE_STAR, MODE_SLASH, MODE_PERCENT: begin
        k = (scan_mode == MODE_STAR) ? KIND_MUL :
            (scan_mode == MODE_SLASH) ? KIND_DIV : KIND_MOD;
        if (c == CH_EQ) begin
          res[n] = make_tok(k + 5'd1, scan_pstart, PosBits'(2));
          taken  = 1'b1;
        end else begin
          res[n] = make_tok(k, scan_pstart, PosBits'(1));
        end
        n++;
      end
      default: begin
      end
    endcase

    // Handle the byte itself as if idle
    if (!taken) begin
      scan_mode = MODE_IDLE;
      k = punct_of(c);
      if (c == CH_NUL) begin
        res[n] = make_tok(KIND_END, p, '0);
        n++;
        res[n-1].last = 1'b1;
        scan_pos = '0;
        return;
      end else if (is_blank(c)) begin
        // skip whitespace
      end else if (is_letter(c)) begin
        scan_mode   = MODE_IDENT;
        scan_pstart = p;
      end else if (is_digit_ch(c)) begin
        scan_mode   = MODE_NUMBER;
        scan_pstart = p;
      end else if (c == CH_PLUS) begin
        scan_mode   = MODE_PLUS;
        scan_pstart = p;
      end else if (c == CH_MINUS) begin
        scan_mode   = MODE_MINUS;
        scan_pstart = p;
      end else if (c == CH_STAR) begin
        scan_mode   = MODE_STAR;
        scan_pstart = p;
      end else if (c == CH_SLASH) begin
        scan_mode   = MODE_SLASH;
        scan_pstart = p;
      end else if (c == CH_PERCENT) begin
        scan_mode   = MODE_PERCENT;
        scan_pstart = p;
      end else if (k != KIND_END) begin
        res[n] = make_tok(k, p, PosBits'(1));
        n++;
      end else begin
        res[n] = make_tok(KIND_ERROR, p, PosBits'(1));
        n++;
        scan_mode = MODE_HALT;
      end
    end else if (scan_mode != MODE_IDENT && scan_mode != MODE_NUMBER) begin
      scan_mode = MODE_IDLE;
    end

    // Hold the position once it saturates
    if (p < PosMax) scan_pos = p + 1'b1;
    if (n > 0) res[n-1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < 50) begin
      $display("token %0d: %s got %0d, expected %0d", tokens_seen, what, got, want);
    end
    err_count++;
  endtask

  // Compare one accepted token with the oldest prediction
  task automatic check_token();
    tok_t want;
    tokens_seen++;
    if (tokens_due.size() == 0) begin
      report_mismatch("unpredicted token, kind", int'(token_kind_o), -1);
      return;
    end
    want = tokens_due.pop_front();
    if (token_kind_o !== want.kind)
      report_mismatch("kind", int'(token_kind_o), int'(want.kind));
    if (token_start_o !== want.start)
      report_mismatch("start", int'(token_start_o), int'(want.start));
    if (token_length_o !== want.length)
      report_mismatch("length", int'(token_length_o), int'(want.length));
    if (last_of_run_o !== want.last)
      report_mismatch("last_of_run", int'(last_of_run_o), int'(want.last));
  endtask

  // Predict the tokens of one byte, then hand the byte over
  task automatic feed(input logic [7:0] c, input logic typed, input tok_t want);
    tok_t res [2];
    int   n;
    lex_byte(c, n, res);
    if (typed) tokens_due.push_back(want);
    else for (int i = 0; i < n; i++) tokens_due.push_back(res[i]);
    // Idle in bursts before raising valid
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and wait for every predicted token to arrive
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tokens_due.size() != 0);
  endtask

  // Build one well-formed text of random tokens, mixed with legal noise
  task automatic build_text();
    int         ntok;
    int         idx;
    logic [7:0] c;
    ntok = $urandom_range(0, 12);
    for (int t = 0; t < ntok; t++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 8)) begin
            c = $urandom_range(0, 1) ? 8'h61 : 8'h41;
            text_buf.push_back(8'(c + $urandom_range(0, 25)));
          end
        end
        2: repeat ($urandom_range(1, 6)) text_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
        3, 4: begin
          idx = $urandom_range(0, 7);
          text_buf.push_back(OpPairs[2*idx]);
          text_buf.push_back(OpPairs[2*idx+1]);
        end
        5: text_buf.push_back(OpSingles[$urandom_range(0, 4)]);
        6: text_buf.push_back(PunctChars[$urandom_range(0, 14)]);
        7: begin
          repeat ($urandom_range(1, 3)) begin
            c = ($urandom_range(0, 5) == 5) ? 8'h20 : 8'(8'h09 + $urandom_range(0, 4));
            text_buf.push_back(c);
          end
        end
        default: begin
          do c = 8'($urandom_range(1, 127));
          while (!(is_blank(c) || is_letter(c) || is_digit_ch(c) || punct_of(c) != KIND_END ||
                   c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PERCENT}));
          text_buf.push_back(c);
        end
      endcase
      if ($urandom_range(0, 2) == 0) text_buf.push_back(8'h20);
    end
    text_buf.push_back(CH_NUL);
  endtask

  // Output side: check accepted tokens and stall in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) check_token();
      if (!sink_idle_on) begin
        stall_left = 0;
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    int rand_count;
    int tail_count;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    text_byte_i  <= 8'h00;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    err_count    = 0;
    tokens_seen  = 0;
    rand_count   = 0;
    tail_count   = 0;
    scan_mode    = MODE_IDLE;
    scan_pos     = '0;
    scan_pstart  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (DirRows[i]) feed(DirRows[i].ch, DirRows[i].typed, DirRows[i].want);

    // Hold off until the scanner has delivered everything
    drain_tokens();

    // Random texts
    while (rand_count < RandItems) begin
      build_text();
      while (text_buf.size() != 0) begin
        feed(text_buf.pop_front(), 1'b0, NoTok);
        rand_count++;
      end
    end

    // No idling from here on
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;

    // Random texts back to back
    while (tail_count < TailItems) begin
      build_text();
      while (text_buf.size() != 0) begin
        feed(text_buf.pop_front(), 1'b0, NoTok);
        tail_count++;
      end
    end

    // Unexpected byte at offset zero, then bytes the halted scanner drops
    feed(CH_NUL, 1'b0, NoTok);
    feed(8'($urandom_range(128, 255)), 1'b1, '{KIND_ERROR, 16'd0, 16'd1, 1'b1});
    repeat (40) feed(8'($urandom_range(0, 255)), 1'b0, NoTok);
    feed(CH_NUL, 1'b0, NoTok);

    drain_tokens();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ operator_token_scanner.f @@
rtl/ots_pkg.sv
rtl/ots_lexer.sv
rtl/ots_tok_fifo.sv
rtl/operator_token_scanner.sv
verif/tb_top.sv
